[sv/lru_key_value_cache_core_defines.svh]
// ---------------------------------------------------------------------------
// lru key/value cache assertion macros
// shared concurrent assertion shorthands, clocked on clk, idle in reset
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// same-cycle implication
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/lkvc_pkg.sv]
// ---------------------------------------------------------------------------
// lkvc_pkg
// fixed widths, codes and control types of the lru key/value cache
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

	localparam int KeyW = 32;
	localparam int ValW = 32;
	localparam int CapW = 5;

	localparam logic [CapW-1:0] CapReset  = 5'd16;
	localparam logic [ValW-1:0] MissValue = {ValW{1'b1}};

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	// per-cycle command broadcast along the cell chain
	typedef struct packed {
		logic shift;   // cells at or below pos take their upstream neighbor
		logic update;  // cell at pos overwrites its value
	} cell_ctl_t;

endpackage

`default_nettype wire

[sv/lkvc_cell.sv]
// ---------------------------------------------------------------------------
// lkvc_cell
// one recency slot: key, value and valid, compare against the lookup key
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkvc_cell #(
	parameter int IDX = 0,
	parameter int IW  = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lkvc_pkg::cell_ctl_t         ctl,
	input  wire logic [IW-1:0]               pos,
	input  wire logic [lkvc_pkg::KeyW-1:0]   lookup_key,
	input  wire logic [lkvc_pkg::ValW-1:0]   upd_value,
	input  wire logic                        prev_valid,
	input  wire logic [lkvc_pkg::KeyW-1:0]   prev_key,
	input  wire logic [lkvc_pkg::ValW-1:0]   prev_value,
	output logic                             valid,
	output logic [lkvc_pkg::KeyW-1:0]        key,
	output logic [lkvc_pkg::ValW-1:0]        value,
	output logic                             match
);

	logic take;
	logic upd;
	logic valid_q;
	logic [lkvc_pkg::KeyW-1:0] key_q;
	logic [lkvc_pkg::ValW-1:0] value_q;

	assign take  = ctl.shift && (IW'(IDX) <= pos);
	assign upd   = ctl.update && (IW'(IDX) == pos);
	assign match = valid_q && (key_q == lookup_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end else if (upd) begin
			value_q <= upd_value;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign value = value_q;

endmodule

`default_nettype wire

[sv/lru_key_value_cache_core.sv]
// ---------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key/value cache with least-recently-used replacement
// ---------------------------------------------------------------------------
// A get request returns hit and the stored value (or all ones on a miss) and
// moves the entry to most recent; a put request updates a present key in place
// or inserts a new key as most recent, evicting the least recent entry once the
// capacity register is reached; a put gives no result. Entries sit in a chain of
// cells ordered by recency, cell 0 most recent, valid cells packed at the front.
// Each request is captured, then executed: every cell compares the key in
// parallel and, on a get hit or insert, the chain shifts by one place to open
// the front. A get waits in the capture stage while the previous result is still
// stalled at the output. No clearing pass after reset: valid bits reset at once.
// capacity must be written only while no request is in flight; the block does
// not enforce it; above ENTRIES it acts as ENTRIES, zero makes every put a no-op.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_key_value_cache_core_defines.svh"

module lru_key_value_cache_core #(
	parameter int ENTRIES = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               operation,
	input  wire logic signed [lkvc_pkg::KeyW-1:0]   key,
	input  wire logic signed [lkvc_pkg::ValW-1:0]   value,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    hit,
	output logic signed [lkvc_pkg::ValW-1:0]        read_value,
	// capacity register write
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [lkvc_pkg::CapW-1:0]          capacity
);

	localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CntW = $clog2(ENTRIES + 1);
	localparam int CmpW = (CntW > lkvc_pkg::CapW) ? CntW : lkvc_pkg::CapW;

	// capacity register
	logic [lkvc_pkg::CapW-1:0] capacity_q;

	// capture stage
	logic                      busy_q;
	logic                      op_s1;
	logic [lkvc_pkg::KeyW-1:0] key_s1;
	logic [lkvc_pkg::ValW-1:0] value_s1;

	// number of valid cells, always a packed prefix of the chain
	logic [CntW-1:0] count_q;

	// output register
	logic                      out_valid_q;
	logic                      hit_q;
	logic [lkvc_pkg::ValW-1:0] read_value_q;

	// chain wiring
	logic [ENTRIES-1:0]        valid_vec;
	logic [ENTRIES-1:0]        match_vec;
	logic [lkvc_pkg::KeyW-1:0] key_arr   [ENTRIES];
	logic [lkvc_pkg::ValW-1:0] value_arr [ENTRIES];

	// execute-cycle decode
	logic                      accept;
	logic                      exec;
	logic                      is_put;
	logic                      any_hit;
	logic [IdxW-1:0]           hit_idx;
	logic [lkvc_pkg::ValW-1:0] hit_value;
	logic [CmpW-1:0]           cap_sat;
	logic                      cap_zero;
	logic                      full;
	logic                      get_hit;
	logic                      put_update;
	logic                      put_insert;
	logic [IdxW-1:0]           pos;
	logic [lkvc_pkg::ValW-1:0] front_value;
	lkvc_pkg::cell_ctl_t       ctl;

	// one request in flight at a time
	assign in_stall  = busy_q;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// a get needs a free output register before it may run
	assign is_put = (op_s1 == lkvc_pkg::OP_PUT);
	assign exec   = busy_q && (is_put || !(out_valid_q && out_stall));

	// keys are unique among valid cells, so the match vector is one-hot or empty
	always_comb begin
		hit_idx   = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i]) begin
				hit_idx   = hit_idx | IdxW'(i);
				hit_value = hit_value | value_arr[i];
			end
		end
	end
	assign any_hit = |match_vec;

	// capacity above the chain length saturates
	always_comb begin
		cap_sat = CmpW'(capacity_q);
		if (CmpW'(capacity_q) > CmpW'(ENTRIES)) begin
			cap_sat = CmpW'(ENTRIES);
		end
	end
	assign cap_zero = (capacity_q == '0);
	assign full     = (CmpW'(count_q) >= cap_sat);

	assign get_hit    = !is_put && any_hit;
	assign put_update = is_put && !cap_zero && any_hit;
	assign put_insert = is_put && !cap_zero && !any_hit;

	// pos: last cell that takes its neighbor, or the cell rewritten in place;
	// an insert into a full cache pushes the least recent entry off the end
	always_comb begin
		priority if (get_hit || put_update) begin
			pos = hit_idx;
		end else if (full) begin
			pos = count_q[IdxW-1:0] - IdxW'(1);
		end else begin
			pos = count_q[IdxW-1:0];
		end
	end

	// a hit entry re-enters at the front with its stored value
	assign front_value = get_hit ? hit_value : value_s1;

	assign ctl.shift  = exec && (get_hit || put_insert);
	assign ctl.update = exec && put_update;

	// recency chain, cell 0 is most recent
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic                      prev_valid;
		logic [lkvc_pkg::KeyW-1:0] prev_key;
		logic [lkvc_pkg::ValW-1:0] prev_value;

		if (i == 0) begin : g_front
			assign prev_valid = 1'b1;
			assign prev_key   = key_s1;
			assign prev_value = front_value;
		end else begin : g_link
			assign prev_valid = valid_vec[i-1];
			assign prev_key   = key_arr[i-1];
			assign prev_value = value_arr[i-1];
		end

		lkvc_cell #(
			.IDX (i),
			.IW  (IdxW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.pos        (pos),
			.lookup_key (key_s1),
			.upd_value  (value_s1),
			.prev_valid (prev_valid),
			.prev_key   (prev_key),
			.prev_value (prev_value),
			.valid      (valid_vec[i]),
			.key        (key_arr[i]),
			.value      (value_arr[i]),
			.match      (match_vec[i])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= lkvc_pkg::CapReset;
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= capacity;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (exec && put_insert && !full) begin
				count_q <= count_q + CntW'(1);
			end
			if (exec && !is_put) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			key_s1   <= key;
			value_s1 <= value;
		end
		if (exec && !is_put) begin
			hit_q        <= any_hit;
			read_value_q <= any_hit ? hit_value : lkvc_pkg::MissValue;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

	// valid cells always form a prefix and agree with the count
	`LKVC_ASSERT_NOW(a_valid_prefix, 1'b1, (valid_vec & (valid_vec + ENTRIES'(1))) == '0, "valid cells not packed at the front")
	`LKVC_ASSERT_NOW(a_count_match, 1'b1, count_q == CntW'($countones(valid_vec)), "entry count disagrees with valid cells")
	// keys stay unique among valid cells
	`LKVC_ASSERT_NOW(a_match_onehot, busy_q, $onehot0(match_vec), "lookup key matches more than one cell")
	// a pending result is never overwritten by a later get
	`LKVC_ASSERT_NEXT(a_result_kept, out_valid_q && out_stall, out_valid_q && $stable(read_value_q), "stalled result lost")

endmodule

`default_nettype wire

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the lru key/value cache core
// ---------------------------------------------------------------------------
// A queue of requests, capacity writes and idling modes is built at time 0
// and fed to the cache by a clocked driver. A clocked monitor runs its own
// recency-ordered cache model on every accepted request and compares each
// read result, field by field, with the oldest predicted read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH         = 16;   // entries of the block under test
	localparam int SETTLE_CYCLES = 6;    // quiet cycles after the last read, covers a put
	localparam int TAIL_CYCLES   = 20;
	localparam int IDLE_LIMIT    = 4000; // cycles with no handshake at all
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 140;

	typedef enum logic [1:0] {
		ITEM_REQ,    // one request on the input channel
		ITEM_CFG,    // capacity write
		ITEM_DRAIN,  // hold off until every read has come back
		ITEM_MODE    // new idling percentages
	} item_kind_t;

	typedef struct {
		item_kind_t       kind;
		lkvc_pkg::op_t    op;
		logic [31:0]      key;
		logic [31:0]      value;
	} stim_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] data;
	} read_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic                             operation = 1'b0;
	logic signed [lkvc_pkg::KeyW-1:0] key       = '0;
	logic signed [lkvc_pkg::ValW-1:0] value     = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             hit;
	logic signed [lkvc_pkg::ValW-1:0] read_value;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [lkvc_pkg::CapW-1:0]        capacity  = lkvc_pkg::CapReset;

	lru_key_value_cache_core #(
		.ENTRIES(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.read_value(read_value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.capacity  (capacity)
	);

	// pending stimulus and predicted reads
	stim_t stim_q[$];
	read_t pending_reads[$];
	int    results_owed  = 0;  // size of pending_reads as of the last edge
	int    mismatches    = 0;
	int    send_idle_pct = 0;
	int    stall_pct     = 0;
	int    hold_cycles   = 0;
	int    quiet_cycles  = 0;

	// cache model: slot contents plus recency age, age 0 is most recent
	logic [31:0]               slot_key[DEPTH];
	logic [31:0]               slot_val[DEPTH];
	bit                        slot_live[DEPTH];
	int unsigned               slot_age[DEPTH];
	int unsigned               live_count;
	logic [lkvc_pkg::CapW-1:0] cap_reg;

	// applies one request to the model, returns 1 when it yields a read
	function automatic bit lookup_or_store(input lkvc_pkg::op_t op, input logic [31:0] k,
			input logic [31:0] v, output read_t res);
		int          found;
		int          slot;
		int unsigned cap;
		int unsigned age;
		bit          evicted;
		res = '0;
		cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
		found = -1;
		for (int i = 0; i < DEPTH; i++)
			if (found < 0 && slot_live[i] && slot_key[i] == k)
				found = i;
		if (op == lkvc_pkg::OP_PUT) begin
			// capacity zero drops every put, updates too
			if (cap == 0)
				return 1'b0;
			if (found >= 0) begin
				// update in place, recency untouched
				slot_val[found] = v;
				return 1'b0;
			end
			// full (or capacity lowered under the fill): drop only the oldest
			if (live_count >= cap) begin
				evicted = 1'b0;
				for (int i = 0; i < DEPTH; i++)
					if (!evicted && slot_live[i] && slot_age[i] + 1 == live_count) begin
						slot_live[i] = 1'b0;
						live_count--;
						evicted = 1'b1;
					end
			end
			slot = -1;
			for (int i = 0; i < DEPTH; i++) begin
				if (!slot_live[i]) begin
					if (slot < 0)
						slot = i;
				end else begin
					slot_age[i]++;
				end
			end
			if (slot >= 0) begin
				slot_live[slot] = 1'b1;
				slot_key[slot]  = k;
				slot_val[slot]  = v;
				slot_age[slot]  = 0;
				live_count++;
			end
			return 1'b0;
		end
		if (found < 0) begin
			res.hit  = 1'b0;
			res.data = lkvc_pkg::MissValue;
			return 1'b1;
		end
		// hit: everything newer ages by one, this entry becomes newest
		age = slot_age[found];
		for (int i = 0; i < DEPTH; i++)
			if (slot_live[i] && slot_age[i] < age)
				slot_age[i]++;
		slot_age[found] = 0;
		res.hit  = 1'b1;
		res.data = slot_val[found];
		return 1'b1;
	endfunction

	function automatic void queue_request(input lkvc_pkg::op_t op, input logic [31:0] k,
			input logic [31:0] v);
		stim_t s;
		s.kind  = ITEM_REQ;
		s.op    = op;
		s.key   = k;
		s.value = v;
		stim_q.push_back(s);
	endfunction

	function automatic void queue_control(input item_kind_t kind, input logic [31:0] a,
			input logic [31:0] b);
		stim_t s;
		s.kind  = kind;
		s.op    = lkvc_pkg::OP_GET;
		s.key   = a;
		s.value = b;
		stim_q.push_back(s);
	endfunction

	// capacity change: settle first so no request is in flight
	function automatic void queue_capacity(input logic [lkvc_pkg::CapW-1:0] c);
		queue_control(ITEM_DRAIN, 0, 0);
		queue_control(ITEM_CFG, 0, 32'(c));
	endfunction

	initial begin
		forever #1 clk = ~clk;
	end

	// driver: one nonblocking assignment per signal per edge
	always @(posedge clk or negedge arst_n) begin : driver
		stim_t nxt;
		logic  drive_req;
		logic  drive_cfg;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			operation     <= lkvc_pkg::OP_GET;
			key           <= '0;
			value         <= '0;
			cfg_valid     <= 1'b0;
			capacity      <= lkvc_pkg::CapReset;
			hold_cycles   <= 0;
			send_idle_pct <= 0;
			stall_pct     <= 0;
		end else begin
			drive_req = 1'b0;
			drive_cfg = 1'b0;
			if (in_valid && in_stall) begin
				// stalled request holds its payload
				drive_req = 1'b1;
			end else if (cfg_valid && !cfg_ready) begin
				drive_cfg = 1'b1;
			end else if (hold_cycles != 0) begin
				hold_cycles <= hold_cycles - 1;
			end else if (stim_q.size() != 0) begin
				nxt = stim_q[0];
				case (nxt.kind)
					ITEM_MODE: begin
						// sender percentage in the first word, receiver in the second
						send_idle_pct <= nxt.key;
						stall_pct     <= nxt.value;
						void'(stim_q.pop_front());
					end
					ITEM_DRAIN: begin
						// a request taken at this edge is not yet in results_owed
						if (!(in_valid && !in_stall) && results_owed == 0) begin
							hold_cycles <= SETTLE_CYCLES;
							void'(stim_q.pop_front());
						end
					end
					ITEM_CFG: begin
						drive_cfg = 1'b1;
						capacity  <= nxt.value[lkvc_pkg::CapW-1:0];
						void'(stim_q.pop_front());
					end
					default: begin
						if ($urandom_range(99) >= send_idle_pct) begin
							drive_req = 1'b1;
							operation <= nxt.op;
							key       <= nxt.key;
							value     <= nxt.value;
							void'(stim_q.pop_front());
						end
					end
				endcase
			end
			in_valid  <= drive_req;
			cfg_valid <= drive_cfg;
		end
	end

	// monitor: model update on accepted requests, compare on accepted reads
	always @(posedge clk or negedge arst_n) begin : monitor
		read_t predicted;
		read_t oldest;
		if (!arst_n) begin
			out_stall    <= 1'b0;
			results_owed <= 0;
			for (int i = 0; i < DEPTH; i++) begin
				slot_live[i] = 1'b0;
				slot_age[i]  = 0;
			end
			live_count = 0;
			cap_reg    = lkvc_pkg::CapReset;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_reg = capacity;
			if (in_valid && !in_stall)
				if (lookup_or_store(lkvc_pkg::op_t'(operation), key, value, predicted))
					pending_reads.push_back(predicted);
			if (out_valid && !out_stall) begin
				if (pending_reads.size() == 0) begin
					$error("read with nothing predicted: hit %0d, read_value %0d",
						hit, read_value);
					mismatches++;
				end else begin
					oldest = pending_reads.pop_front();
					if (hit !== oldest.hit) begin
						$error("hit: expected %0d, got %0d", oldest.hit, hit);
						mismatches++;
					end
					if (read_value !== oldest.data) begin
						$error("read_value: expected %0d, got %0d",
							$signed(oldest.data), read_value);
						mismatches++;
					end
				end
			end
			results_owed <= pending_reads.size();
			out_stall    <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on handshake silence
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready) || hold_cycles != 0)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("** lru_key_value_cache_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [31:0]               key_pool[24];
		logic [lkvc_pkg::CapW-1:0] phase_cap[PHASES];
		int                        pool_size;
		int                        mode_idle[4];
		int                        mode_stall[4];
		logic [31:0]               k;
		logic [31:0]               v;
		phase_cap  = '{5'd16, 5'd1, 5'd0, 5'd3, 5'd31, 5'd8,
			5'd2, 5'd17, 5'd15, 5'd5, 5'd4, 5'd16};
		mode_idle  = '{0, 79, 0, 7};
		mode_stall = '{0, 0, 79, 7};

		// directed: empty lookup, key and value extremes, update in place
		queue_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0);
		queue_request(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_request(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_request(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
		queue_request(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_request(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
		queue_request(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);  // stored -1 on a hit
		queue_request(lkvc_pkg::OP_GET, 32'h1234_5678, 32'h0);
		queue_request(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h5555_AAAA);
		queue_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0);
		queue_request(lkvc_pkg::OP_PUT, 32'h0000_0001, 32'h1);
		queue_request(lkvc_pkg::OP_PUT, 32'h0000_0002, 32'h2);
		// capacity zero: inserts and updates dropped, lookups still served
		queue_capacity(5'd0);
		queue_request(lkvc_pkg::OP_PUT, 32'h0000_0003, 32'h3);
		queue_request(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h63);
		queue_request(lkvc_pkg::OP_GET, 32'h0000_0003, 32'h0);
		queue_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0);
		// capacity under the fill: one eviction per new key, fill unchanged
		queue_capacity(5'd2);
		queue_request(lkvc_pkg::OP_PUT, 32'h0000_0004, 32'h4);
		queue_request(lkvc_pkg::OP_GET, 32'h0000_0004, 32'h0);
		queue_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0);
		queue_request(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
		queue_request(lkvc_pkg::OP_GET, 32'h0000_0001, 32'h0);
		queue_request(lkvc_pkg::OP_GET, 32'h0000_0002, 32'h0);

		// random phases: capacity sweep, idling modes, small key pools for hits
		for (int p = 0; p < PHASES; p++) begin
			queue_capacity(p == PHASES - 1 ? 5'($urandom_range(31)) : phase_cap[p]);
			queue_control(ITEM_MODE, mode_idle[p % 4], mode_stall[p % 4]);
			pool_size = $urandom_range(24, 4);
			for (int i = 0; i < 24; i++)
				key_pool[i] = $urandom;
			key_pool[0] = 32'h8000_0000;
			key_pool[1] = 32'h7FFF_FFFF;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_size - 1)]
					: $urandom;
				v = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
				queue_request($urandom_range(1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, k, v);
			end
		end
		queue_control(ITEM_DRAIN, 0, 0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stim_q.size() != 0 || in_valid || cfg_valid || results_owed != 0 ||
				hold_cycles != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (pending_reads.size() != 0) begin
			$error("%0d predicted reads never arrived", pending_reads.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("** lru_key_value_cache_core: PASSED **");
		else
			$display("** lru_key_value_cache_core: FAILED **");
		$finish;
	end

endmodule

[lru_key_value_cache_core.f]
+incdir+sv
sv/lkvc_pkg.sv
sv/lkvc_cell.sv
sv/lru_key_value_cache_core.sv
tb/tb.sv
